// ===== rtl/espr_pkg.sv =====
// espr_pkg: shared types and constants for the expert slab read planner
// no dependencies
`timescale 1ns / 1ps

package espr_pkg;

    localparam int SLAB_SLOTS = 16;
    localparam int MAX_ALIGN  = 30;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_FETCH = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_OVFL    = 2'd2,
        ST_NONE    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        REG_EXPERTS = 3'd0,
        REG_SLABS   = 3'd1,
        REG_BASE    = 3'd2,
        REG_RECSIZE = 3'd3,
        REG_ALIGN   = 3'd4
    } reg_index_t;

    // settings the offset unit works from
    typedef struct packed {
        logic [63:0] base;
        logic [31:0] rec;
        logic [4:0]  al;
    } calc_cfg_t;

    typedef struct packed {
        logic        ovf;
        logic [63:0] off;
        logic [63:0] start;
        logic [32:0] len;
    } calc_res_t;

endpackage

// ===== rtl/espr_ram.sv =====
// espr_ram: generic single-write, single-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module espr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/espr_offset.sv =====
// espr_offset: three-stage record offset unit (multiply, add, align)
// depends on espr_pkg
`timescale 1ns / 1ps

module espr_offset #(
    parameter int IDX_W = 13
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  logic [IDX_W-1:0]      idx,
    input  espr_pkg::calc_cfg_t   cfg,
    output logic                  done,
    output espr_pkg::calc_res_t   res
);
    import espr_pkg::*;

    logic                 v1_reg, v2_reg, v3_reg;
    logic [IDX_W+31:0]    prod_reg;
    logic [64:0]          sum_reg;
    calc_res_t            res_reg;
    logic [63:0]          amask;
    logic [33:0]          lsum;

    assign amask = (64'(1) << cfg.al) - 64'(1);
    assign lsum  = 34'(sum_reg[29:0] & amask[29:0]) + 34'(cfg.rec) + 34'(amask[29:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= go;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg      <= (IDX_W+32)'(idx) * (IDX_W+32)'(cfg.rec);
        // carry out of the 65-bit sum marks offset overflow
        sum_reg       <= {1'b0, cfg.base} + 65'(prod_reg);
        res_reg.ovf   <= sum_reg[64];
        res_reg.off   <= sum_reg[63:0];
        res_reg.start <= sum_reg[63:0] & ~amask;
        res_reg.len   <= 33'(lsum & ~34'(amask[29:0]));
    end

    assign done = v3_reg;
    assign res  = res_reg;

endmodule

// ===== rtl/expert_slab_read_planner.sv =====
// expert_slab_read_planner: top level, fsm around the slab bitmap ram
// depends on espr_pkg, espr_ram, espr_offset
// one item at a time: in_stall is high outside the idle state; a fetch scans the bitmap word by word
// and runs the offset unit on a hit; a clear action reruns the clearing pass below
// reset sets the control registers and configuration defaults, then runs a clearing pass over the bitmap
// during the clearing pass no item is taken; configuration writes are taken as ever
`timescale 1ns / 1ps

module expert_slab_read_planner #(
    parameter int MAX_EXPERTS = 512,
    parameter int MAX_SLABS   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [8:0]  expert_id,
    input  logic [7:0]  part_tag,
    input  logic [31:0] weight_raw,
    input  logic [15:0] slab_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [8:0]  read_expert,
    output logic [3:0]  read_slab,
    output logic [63:0] record_start,
    output logic [63:0] aligned_start,
    output logic [32:0] aligned_length,
    output logic [31:0] requested_total
);
    import espr_pkg::*;

    localparam int AW    = MAX_EXPERTS > 1 ? $clog2(MAX_EXPERTS) : 1;
    localparam int TOTAL = MAX_EXPERTS * SLAB_SLOTS;
    localparam int CW    = $clog2(TOTAL + 1);
    localparam int IDX_W = AW + 4;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_ADD, S_SCAN, S_CALC, S_RESP
    } state_t;

    state_t         state_reg;
    logic [AW-1:0]  clr_addr_reg;
    logic           clr_resp_reg;
    logic [CW-1:0]  cursor_reg;
    logic           fault_reg;
    logic [31:0]    count_reg;
    logic [15:0]    mask_reg;
    logic [AW-1:0]  add_addr_reg;
    logic [IDX_W-1:0] idx_reg;
    logic           go_reg;
    status_t        res_status_reg;
    logic [8:0]     res_e_reg;
    logic [3:0]     res_n_reg;
    logic [63:0]    res_rec_reg, res_start_reg;
    logic [32:0]    res_len_reg;

    logic           ov_reg;
    logic [1:0]     o_status_reg;
    logic [8:0]     o_e_reg;
    logic [3:0]     o_n_reg;
    logic [63:0]    o_rec_reg, o_start_reg;
    logic [32:0]    o_len_reg;
    logic [31:0]    o_tot_reg;

    logic [9:0]     experts_reg;
    logic [4:0]     slabs_reg;
    logic [63:0]    base_reg;
    logic [31:0]    recsize_reg;
    logic [4:0]     align_reg;

    logic           accept, cfg_wr;
    logic [2:0]     cfg_idx;
    logic [4:0]     eff_slabs;
    logic [15:0]    allowed;
    logic           route_ok;
    logic [4:0]     pop;
    logic [32:0]    cnt_sum;
    logic [AW-1:0]  cur_e;
    logic [15:0]    word;
    logic           hit;
    logic [3:0]     hit_n;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [15:0]    ram_wdata, ram_rdata;
    calc_cfg_t      calc_cfg;
    logic           calc_done;
    calc_res_t      calc_res;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign cfg_idx   = paddr[5:3];
    assign eff_slabs = (32'(slabs_reg) > MAX_SLABS) ? 5'(MAX_SLABS) : slabs_reg;
    assign allowed   = 16'((17'(1) << eff_slabs) - 17'(1));
    assign cur_e     = cursor_reg[AW+3:4];
    assign word      = ram_rdata & (16'hFFFF << cursor_reg[3:0]);

    assign route_ok = (10'(expert_id) < experts_reg)
                   && (32'(expert_id) < MAX_EXPERTS)
                   && (part_tag <= 8'd1)
                   && (weight_raw[30:23] != 8'hFF)
                   && ((slab_bits & ~allowed) == 16'd0);

    always_comb
    begin
        pop = 5'd0;
        for (int i = 0; i < SLAB_SLOTS; i++)
        begin
            pop = pop + 5'(mask_reg[i]);
        end
    end
    assign cnt_sum = {1'b0, count_reg} + 33'(pop);

    // lowest set bit of the masked word
    always_comb
    begin
        hit_n = 4'd0;
        for (int i = SLAB_SLOTS - 1; i >= 0; i--)
        begin
            if (word[i])
            begin
                hit_n = 4'(i);
            end
        end
    end
    assign hit = (word != 16'd0);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = add_addr_reg;
        ram_wdata = ram_rdata | mask_reg;
        ram_raddr = cur_e;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = 16'd0;
            end
            S_IDLE:
            begin
                if (action_t'(action) == ACT_ADD)
                begin
                    ram_raddr = AW'(expert_id);
                end
            end
            S_ADD:
            begin
                ram_we = 1'b1;
            end
            S_SCAN:
            begin
                ram_raddr = cur_e + AW'(1);
            end
            default:
            begin
            end
        endcase
    end

    espr_ram #(.WIDTH(SLAB_SLOTS), .DEPTH(MAX_EXPERTS)) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign calc_cfg.base = base_reg;
    assign calc_cfg.rec  = recsize_reg;
    assign calc_cfg.al   = (align_reg > 5'(MAX_ALIGN)) ? 5'(MAX_ALIGN) : align_reg;

    espr_offset #(.IDX_W(IDX_W)) u_offset (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go_reg),
        .idx   (idx_reg),
        .cfg   (calc_cfg),
        .done  (calc_done),
        .res   (calc_res)
    );

    always_comb
    begin
        prdata = 64'd0;
        unique case (cfg_idx)
            REG_EXPERTS: prdata = 64'(experts_reg);
            REG_SLABS:   prdata = 64'(slabs_reg);
            REG_BASE:    prdata = base_reg;
            REG_RECSIZE: prdata = 64'(recsize_reg);
            REG_ALIGN:   prdata = 64'(align_reg);
            default:     prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            experts_reg <= 10'd512;
            slabs_reg   <= 5'd16;
            base_reg    <= 64'd0;
            recsize_reg <= 32'd4096;
            align_reg   <= 5'd12;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_EXPERTS: experts_reg <= pwdata[9:0];
                REG_SLABS:   slabs_reg   <= pwdata[4:0];
                REG_BASE:    base_reg    <= pwdata;
                REG_RECSIZE: recsize_reg <= pwdata[31:0];
                REG_ALIGN:   align_reg   <= pwdata[4:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            clr_resp_reg <= 1'b0;
            cursor_reg   <= '0;
            fault_reg    <= 1'b0;
            count_reg    <= 32'd0;
            go_reg       <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            go_reg <= (state_reg == S_SCAN) && hit;
            // a held result stays until its transfer, S_RESP always leaves one
            ov_reg <= (state_reg == S_RESP) || (ov_reg && out_stall);
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (32'(clr_addr_reg) == MAX_EXPERTS - 1)
                    begin
                        state_reg <= clr_resp_reg ? S_RESP : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_e_reg      <= 9'd0;
                        res_n_reg      <= 4'd0;
                        res_rec_reg    <= 64'd0;
                        res_start_reg  <= 64'd0;
                        res_len_reg    <= 33'd0;
                        case (action_t'(action))
                            ACT_CLEAR:
                            begin
                                count_reg      <= 32'd0;
                                fault_reg      <= 1'b0;
                                cursor_reg     <= '0;
                                clr_addr_reg   <= '0;
                                clr_resp_reg   <= 1'b1;
                                res_status_reg <= ST_OK;
                                state_reg      <= S_CLEAR;
                            end
                            ACT_ADD:
                            begin
                                mask_reg       <= slab_bits;
                                add_addr_reg   <= AW'(expert_id);
                                res_status_reg <= route_ok ? ST_OK : ST_INVALID;
                                state_reg      <= route_ok ? S_ADD : S_RESP;
                                if (!route_ok)
                                begin
                                    fault_reg <= 1'b1;
                                end
                            end
                            ACT_FETCH:
                            begin
                                if (fault_reg)
                                begin
                                    res_status_reg <= ST_INVALID;
                                    state_reg      <= S_RESP;
                                end
                                else if (32'(cursor_reg) >= TOTAL)
                                begin
                                    res_status_reg <= ST_NONE;
                                    state_reg      <= S_RESP;
                                end
                                else
                                begin
                                    res_status_reg <= ST_OK;
                                    state_reg      <= S_SCAN;
                                end
                            end
                            default:
                            begin
                                res_status_reg <= ST_OK;
                                state_reg      <= S_RESP;
                            end
                        endcase
                    end
                end
                S_ADD:
                begin
                    count_reg <= cnt_sum[32] ? 32'hFFFF_FFFF : cnt_sum[31:0];
                    state_reg <= S_RESP;
                end
                S_SCAN:
                begin
                    if (hit)
                    begin
                        cursor_reg <= CW'({cur_e, hit_n}) + CW'(1);
                        idx_reg    <= IDX_W'(cur_e) * IDX_W'(eff_slabs) + IDX_W'(hit_n);
                        res_e_reg  <= 9'(cur_e);
                        res_n_reg  <= hit_n;
                        state_reg  <= S_CALC;
                    end
                    else if (32'(cur_e) == MAX_EXPERTS - 1)
                    begin
                        cursor_reg     <= CW'(TOTAL);
                        res_status_reg <= ST_NONE;
                        state_reg      <= S_RESP;
                    end
                    else
                    begin
                        cursor_reg <= CW'({cur_e, 4'd0}) + CW'(SLAB_SLOTS);
                    end
                end
                S_CALC:
                begin
                    if (calc_done)
                    begin
                        state_reg <= S_RESP;
                        if (calc_res.ovf)
                        begin
                            res_status_reg <= ST_OVFL;
                        end
                        else
                        begin
                            res_status_reg <= ST_OK;
                            res_rec_reg    <= calc_res.off;
                            res_start_reg  <= calc_res.start;
                            res_len_reg    <= calc_res.len;
                        end
                    end
                end
                S_RESP:
                begin
                    if (!ov_reg || !out_stall)
                    begin
                        o_status_reg <= res_status_reg;
                        o_e_reg      <= res_e_reg;
                        o_n_reg      <= res_n_reg;
                        o_rec_reg    <= res_rec_reg;
                        o_start_reg  <= res_start_reg;
                        o_len_reg    <= res_len_reg;
                        o_tot_reg    <= count_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid       = ov_reg;
    assign status          = o_status_reg;
    assign read_expert     = o_e_reg;
    assign read_slab       = o_n_reg;
    assign record_start    = o_rec_reg;
    assign aligned_start   = o_start_reg;
    assign aligned_length  = o_len_reg;
    assign requested_total = o_tot_reg;

endmodule

// ===== rtl/espr_checker.sv =====
// espr_checker: port-level checks for the expert slab read planner
// depends on espr_pkg; bound to expert_slab_read_planner
`timescale 1ns / 1ps

module espr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [8:0]  read_expert,
    input logic [3:0]  read_slab,
    input logic [63:0] record_start,
    input logic [63:0] aligned_start,
    input logic [32:0] aligned_length,
    input logic [31:0] requested_total
);
    import espr_pkg::*;

    // stalled transfer holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(record_start)
        && $stable(status) && $stable(requested_total))
        else $error("stalled result changed");

    // no read emitted: offset fields are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> record_start == 64'd0
        && aligned_start == 64'd0 && aligned_length == 33'd0)
        else $error("offset fields set without a read");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_INVALID || status == ST_NONE)
        |-> read_expert == 9'd0 && read_slab == 4'd0)
        else $error("read pair set without a read");

    // aligned start never passes the record offset
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK |-> aligned_start <= record_start)
        else $error("aligned start above record offset");

endmodule

bind expert_slab_read_planner espr_checker u_espr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .read_expert     (read_expert),
    .read_slab       (read_slab),
    .record_start    (record_start),
    .aligned_start   (aligned_start),
    .aligned_length  (aligned_length),
    .requested_total (requested_total)
);
